>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> rtl/core/cvv_pkg.sv
package cvv_pkg;

   localparam int BETA_BITS = 16;

   typedef enum logic [0:0] {
      REG_HALF_KICK = 1'b0,
      REG_DRIFT     = 1'b1
   } csr_index_type;

endpackage

>>> rtl/core/cvv_div.sv
module cvv_div #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);
   import cvv_pkg::*;

   // one quotient bit per stage, restoring
   logic [DW-1:0] rem_ff [NW-1];
   logic [DW-1:0] den_ff [NW-1];
   logic [NW-1:0] num_ff [NW-1];
   logic [NW-1:0] quo_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [DW-1:0] r_p;
      logic [DW-1:0] d_p;
      logic [NW-1:0] n_p;
      logic [NW-1:0] q_p;
      logic [DW:0]   t;
      logic          ge;
      logic [DW-1:0] rem_in;

      if (i == 0) begin : g_first
         assign r_p = '0;
         assign d_p = den;
         assign n_p = num;
         assign q_p = '0;
      end else begin : g_next
         assign r_p = rem_ff[i-1];
         assign d_p = den_ff[i-1];
         assign n_p = num_ff[i-1];
         assign q_p = quo_ff[i-1];
      end

      always_comb begin
         t  = {r_p, n_p[NW-1]};
         ge = (t >= {1'b0, d_p});
         rem_in = ge ? DW'(t - {1'b0, d_p}) : t[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[i] <= {q_p[NW-2:0], ge};
         end
      end

      if (i < NW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rem_in;
               den_ff[i] <= d_p;
               num_ff[i] <= {n_p[NW-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = quo_ff[NW-1];

endmodule

>>> rtl/core/cvv_lane.sv
module cvv_lane #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [cvv_pkg::BETA_BITS:0] denom,
   input  logic [W-1:0]              dtfm,
   input  logic                      dtfm_sat,
   input  logic [W-1:0]              drift,
   input  logic                      op,
   input  logic [W-1:0]              force_in,
   input  logic [W-1:0]              vel,
   input  logic [W-1:0]              pos,
   output logic [W-1:0]              new_vel,
   output logic [W-1:0]              new_pos,
   output logic                      sat
);
   import cvv_pkg::*;

   localparam int NW = W + ((F > BETA_BITS) ? F : BETA_BITS);
   localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NEG_MAG = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return {1'b1, s[W] ? NEG_MAG : POS_MAX};
      end
      return {1'b0, s[W-1:0]};
   endfunction

   logic [W-1:0]  fm;
   logic [NW-1:0] fc_num;
   logic [NW-1:0] fc_q;

   assign fm     = force_in[W-1] ? W'(-force_in) : force_in;
   assign fc_num = NW'({fm, {BETA_BITS{1'b0}}});

   cvv_div #(.NW(NW), .DW(BETA_BITS + 1)) u_div (
      .clock (clock),
      .en    (en),
      .num   (fc_num),
      .den   (denom),
      .quo   (fc_q)
   );

   // side line alongside the divider
   logic         op_q_ff  [NW];
   logic         neg_q_ff [NW];
   logic [W-1:0] v_q_ff   [NW];
   logic [W-1:0] x_q_ff   [NW];

   always_ff @(posedge clock) begin
      if (en) begin
         op_q_ff[0]  <= op;
         neg_q_ff[0] <= force_in[W-1];
         v_q_ff[0]   <= vel;
         x_q_ff[0]   <= pos;
         for (int i = 1; i < NW; i++) begin
            op_q_ff[i]  <= op_q_ff[i-1];
            neg_q_ff[i] <= neg_q_ff[i-1];
            v_q_ff[i]   <= v_q_ff[i-1];
            x_q_ff[i]   <= x_q_ff[i-1];
         end
      end
   end

   // A: clip corrected force
   logic [W-1:0] lim_a;
   logic         sat_a_in;
   logic [W-1:0] fcm_a_in;
   logic [W-1:0] fcm_a_ff, v_a_ff, x_a_ff;
   logic         op_a_ff, neg_a_ff, flag_a_ff;

   always_comb begin
      lim_a    = neg_q_ff[NW-1] ? NEG_MAG : POS_MAX;
      sat_a_in = (fc_q > NW'(lim_a));
      fcm_a_in = sat_a_in ? lim_a : fc_q[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fcm_a_ff  <= fcm_a_in;
         flag_a_ff <= sat_a_in;
         op_a_ff   <= op_q_ff[NW-1];
         neg_a_ff  <= neg_q_ff[NW-1];
         v_a_ff    <= v_q_ff[NW-1];
         x_a_ff    <= x_q_ff[NW-1];
      end
   end

   // B: kick product
   logic [2*W-1:0] prod_b_ff;
   logic [W-1:0]   v_b_ff, x_b_ff;
   logic           op_b_ff, neg_b_ff, flag_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_b_ff <= fcm_a_ff * dtfm;
         flag_b_ff <= flag_a_ff | dtfm_sat;
         op_b_ff   <= op_a_ff;
         neg_b_ff  <= neg_a_ff;
         v_b_ff    <= v_a_ff;
         x_b_ff    <= x_a_ff;
      end
   end

   // C: clip dv
   logic [2*W-F-1:0] m_c;
   logic [W-1:0]     lim_c, dvm_c;
   logic             sat_c_in;
   logic [W-1:0]     dv_c_ff, v_c_ff, x_c_ff;
   logic             op_c_ff, flag_c_ff;

   always_comb begin
      m_c      = prod_b_ff[2*W-1:F];
      lim_c    = neg_b_ff ? NEG_MAG : POS_MAX;
      sat_c_in = (m_c > (2*W-F)'(lim_c));
      dvm_c    = sat_c_in ? lim_c : m_c[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_c_ff   <= neg_b_ff ? W'(-dvm_c) : dvm_c;
         flag_c_ff <= flag_b_ff | sat_c_in;
         op_c_ff   <= op_b_ff;
         v_c_ff    <= v_b_ff;
         x_c_ff    <= x_b_ff;
      end
   end

   // D: new velocity
   logic [W:0]   vs_d;
   logic [W-1:0] vn_d_ff, x_d_ff;
   logic         op_d_ff, flag_d_ff;

   assign vs_d = add_sat(v_c_ff, dv_c_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         vn_d_ff   <= vs_d[W-1:0];
         flag_d_ff <= flag_c_ff | vs_d[W];
         op_d_ff   <= op_c_ff;
         x_d_ff    <= x_c_ff;
      end
   end

   // E: drift product
   logic [W-1:0]   vm_e;
   logic [2*W-1:0] prod_e_ff;
   logic [W-1:0]   vn_e_ff, x_e_ff;
   logic           op_e_ff, flag_e_ff;

   assign vm_e = vn_d_ff[W-1] ? W'(-vn_d_ff) : vn_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_e_ff <= vm_e * drift;
         vn_e_ff   <= vn_d_ff;
         flag_e_ff <= flag_d_ff;
         op_e_ff   <= op_d_ff;
         x_e_ff    <= x_d_ff;
      end
   end

   // F: clip dx
   logic [2*W-F-1:0] m_f;
   logic [W-1:0]     lim_f, dxm_f;
   logic             sat_f_in;
   logic [W-1:0]     dx_f_ff, vn_f_ff, x_f_ff;
   logic             op_f_ff, flag_f_ff;

   always_comb begin
      m_f      = prod_e_ff[2*W-1:F];
      lim_f    = vn_e_ff[W-1] ? NEG_MAG : POS_MAX;
      sat_f_in = (m_f > (2*W-F)'(lim_f));
      dxm_f    = sat_f_in ? lim_f : m_f[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_f_ff   <= vn_e_ff[W-1] ? W'(-dxm_f) : dxm_f;
         flag_f_ff <= flag_e_ff | (!op_e_ff && sat_f_in);
         op_f_ff   <= op_e_ff;
         vn_f_ff   <= vn_e_ff;
         x_f_ff    <= x_e_ff;
      end
   end

   // G: new position, output register
   logic [W:0]   xs_g;
   logic [W-1:0] vn_g_ff, xn_g_ff;
   logic         flag_g_ff;

   assign xs_g = add_sat(x_f_ff, dx_f_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         vn_g_ff   <= vn_f_ff;
         xn_g_ff   <= op_f_ff ? x_f_ff : xs_g[W-1:0];
         flag_g_ff <= flag_f_ff | (!op_f_ff && xs_g[W]);
      end
   end

   assign new_vel = vn_g_ff;
   assign new_pos = xn_g_ff;
   assign sat     = flag_g_ff;

endmodule

>>> rtl/core/corrected_velocity_verlet_step.sv
// Corrected velocity-Verlet half step, one particle per transfer.
// req_ channel: one particle (mass, beta, force, velocity, position) per
// transfer, op on req_tuser. rsp_ channel: new velocity and position with
// the clip flag on rsp_tuser. csr_ channel writes half_kick_factor (index 0)
// and drift_step (index 1); it is always ready.
// The bit-per-stage dividers (one for the kick, one per lane) make up most
// of the pipeline. Throughput: one particle per cycle while the receiver
// does not stall. Each dimension has its own lane; the lane flags are merged at
// the output.
// Reset empties the pipeline and clears both registers.
// When the receiver stalls the whole pipeline holds and req_tready drops;
// the pipeline keeps moving while the output register is empty or taken.
`include "assert_macros.svh"

module corrected_velocity_verlet_step #(
   parameter int FRAC_BITS  = 16,
   parameter int WORD_BITS  = 32,
   parameter int DIMENSIONS = 3,
   localparam int REQ_W = ((10 * WORD_BITS + cvv_pkg::BETA_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((6 * WORD_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // mass, beta, force x/y/z, vel x/y/z, pos x/y/z
   input  logic [REQ_W-1:0]      req_tdata,
   // op
   input  logic [0:0]            req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // new_vel x/y/z, new_pos x/y/z
   output logic [RSP_W-1:0]      rsp_tdata,
   // saturated
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  cvv_pkg::csr_index_type csr_index,
   input  logic [WORD_BITS-1:0]  csr_data
);
   import cvv_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int NW  = W + ((FRAC_BITS > BETA_BITS) ? FRAC_BITS : BETA_BITS);
   localparam int LAT = NW + 7;
   localparam int FB  = W + BETA_BITS;

   logic [W-1:0] hkf_ff, drift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hkf_ff   <= '0;
         drift_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_HALF_KICK: hkf_ff   <= csr_data;
            REG_DRIFT:     drift_ff <= csr_data;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   logic en;
   logic [LAT-1:0] vld_ff;

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // shared dtfm = half_kick / mass
   logic [W-1:0]     mass;
   logic [NW-1:0]    kick_num, kick_q;
   logic [BETA_BITS:0] denom;
   logic [W-1:0]     dtfm_ff;
   logic             dtfm_sat_ff;
   logic             dtfm_sat_in;

   assign mass     = req_tdata[W-1:0];
   assign denom    = {1'b1, {BETA_BITS{1'b0}}} - {1'b0, req_tdata[FB-1:W]};
   assign kick_num = NW'({hkf_ff, {FRAC_BITS{1'b0}}});

   cvv_div #(.NW(NW), .DW(W)) u_kick_div (
      .clock (clock),
      .en    (en),
      .num   (kick_num),
      .den   (mass),
      .quo   (kick_q)
   );

   assign dtfm_sat_in = (kick_q[NW-1:W] != '0);

   always_ff @(posedge clock) begin
      if (en) begin
         dtfm_ff     <= dtfm_sat_in ? '1 : kick_q[W-1:0];
         dtfm_sat_ff <= dtfm_sat_in;
      end
   end

   logic [2:0] lane_sat;

   for (genvar d = 0; d < 3; d++) begin : g_dim
      logic [W-1:0] nv, np;
      if (d < DIMENSIONS) begin : g_lane
         cvv_lane #(.W(W), .F(FRAC_BITS)) u_lane (
            .clock    (clock),
            .en       (en),
            .denom    (denom),
            .dtfm     (dtfm_ff),
            .dtfm_sat (dtfm_sat_ff),
            .drift    (drift_ff),
            .op       (req_tuser[0]),
            .force_in (req_tdata[FB + d*W +: W]),
            .vel      (req_tdata[FB + (3+d)*W +: W]),
            .pos      (req_tdata[FB + (6+d)*W +: W]),
            .new_vel  (nv),
            .new_pos  (np),
            .sat      (lane_sat[d])
         );
      end else begin : g_pass
         logic [W-1:0] pv_ff [LAT];
         logic [W-1:0] px_ff [LAT];
         always_ff @(posedge clock) begin
            if (en) begin
               pv_ff[0] <= req_tdata[FB + (3+d)*W +: W];
               px_ff[0] <= req_tdata[FB + (6+d)*W +: W];
               for (int i = 1; i < LAT; i++) begin
                  pv_ff[i] <= pv_ff[i-1];
                  px_ff[i] <= px_ff[i-1];
               end
            end
         end
         assign nv          = pv_ff[LAT-1];
         assign np          = px_ff[LAT-1];
         assign lane_sat[d] = 1'b0;
      end
      assign rsp_tdata[d*W +: W]     = nv;
      assign rsp_tdata[(3+d)*W +: W] = np;
   end

   if (RSP_W > 6 * W) begin : g_pad
      assign rsp_tdata[RSP_W-1:6*W] = '0;
   end

   assign rsp_tuser[0] = |lane_sat;

   `ASSERT_CLK(a_empty_ready, clock, reset, !rsp_tvalid |-> req_tready, "empty output must accept")
   `ASSERT_CLK(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(vld_ff), "pipeline moved under stall")
   `ASSERT_NEVER(a_no_take_stalled, clock, reset, req_tready && rsp_tvalid && !rsp_tready, "accepted while stalled")

endmodule

>>> verif/tb_corrected_velocity_verlet_step.sv
typedef struct {
   bit          op;
   logic [31:0] mass;
   logic [15:0] beta;
   logic [31:0] force_v[3];
   logic [31:0] vel[3];
   logic [31:0] pos[3];
} particle_type;

typedef struct {
   logic [191:0] data;
   bit           clipped;
} particle_update_type;

class verlet_scoreboard;
   logic [31:0]         half_kick;
   logic [31:0]         drift;
   particle_update_type pending[$];
   int                  errors;

   function new();
      half_kick = '0;
      drift     = '0;
      errors    = 0;
   endfunction

   function automatic logic [127:0] magnitude(logic [31:0] a);
      longint sa;
      sa = $signed(a);
      if (sa < 0) sa = -sa;
      return 128'(sa);
   endfunction

   function automatic logic [31:0] clip(logic [127:0] m, bit neg, inout bit flag);
      logic [127:0] lim;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (m > lim) begin
         flag = 1;
         m = lim;
      end
      return neg ? -m[31:0] : m[31:0];
   endfunction

   function automatic logic [31:0] add_clip(logic [31:0] a, logic [31:0] b, inout bit flag);
      longint s;
      s = longint'($signed(a)) + longint'($signed(b));
      if (s > 64'sd2147483647) begin
         flag = 1;
         s = 64'sd2147483647;
      end else if (s < -64'sd2147483648) begin
         flag = 1;
         s = -64'sd2147483648;
      end
      return s[31:0];
   endfunction

   function void note_particle(particle_type p);
      particle_update_type r;
      logic [127:0]        q;
      logic [31:0]         dtfm, fc, dv, v, x, dx;
      logic [16:0]         denom;
      bit                  flag, fneg;
      flag  = 0;
      denom = 17'h10000 - p.beta;
      if (p.mass == 0) begin
         dtfm = '1;
         flag = 1;
      end else begin
         q = (128'(half_kick) << 16) / p.mass;
         if (q > 128'hFFFF_FFFF) begin
            flag = 1;
            dtfm = '1;
         end else dtfm = q[31:0];
      end
      for (int d = 0; d < 3; d++) begin
         fneg = p.force_v[d][31];
         fc = clip((magnitude(p.force_v[d]) << 16) / denom, fneg, flag);
         dv = clip((magnitude(fc) * 128'(dtfm)) >> 16, fneg, flag);
         v = add_clip(p.vel[d], dv, flag);
         x = p.pos[d];
         if (p.op == 0) begin
            dx = clip((magnitude(v) * 128'(drift)) >> 16, v[31], flag);
            x = add_clip(x, dx, flag);
         end
         r.data[32*d +: 32]     = v;
         r.data[96 + 32*d +: 32] = x;
      end
      r.clipped = flag;
      pending.push_back(r);
   endfunction

   function void check_result(logic [191:0] data, logic flag);
      particle_update_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result transfer %h", $time, data);
         errors++;
         return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 6; i++)
         if (data[32*i +: 32] !== e.data[32*i +: 32]) begin
            $display("%0t: word %0d expected %h actual %h", $time, i,
                     e.data[32*i +: 32], data[32*i +: 32]);
            errors++;
         end
      if (flag !== e.clipped) begin
         $display("%0t: saturated expected %0d actual %0d", $time, e.clipped, flag);
         errors++;
      end
   endfunction
endclass

module tb_corrected_velocity_verlet_step;
   import cvv_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic [335:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [191:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic         csr_valid = 0;
   logic         csr_ready;
   csr_index_type csr_index = REG_HALF_KICK;
   logic [31:0]  csr_data = '0;

   verlet_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   corrected_velocity_verlet_step dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 0;
      end else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser[0]);
   end

   initial begin
      #2000000;
      $display("tb_corrected_velocity_verlet_step failed");
      $finish;
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == REG_HALF_KICK) sb.half_kick = value;
      else sb.drift = value;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_particle(particle_type p);
      logic [335:0] w;
      w[31:0]  = p.mass;
      w[47:32] = p.beta;
      for (int d = 0; d < 3; d++) begin
         w[48 + 32*d +: 32]  = p.force_v[d];
         w[144 + 32*d +: 32] = p.vel[d];
         w[240 + 32*d +: 32] = p.pos[d];
      end
      req_tdata  <= w;
      req_tuser  <= p.op;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sb.note_particle(p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(3))
         0: w = $urandom;
         1: w = $urandom_range(0, 32'h3FFFF);
         2: case ($urandom_range(4))
               0: w = 0;
               1: w = 1;
               2: w = '1;
               3: w = 32'h8000_0000;
               default: w = 32'h7FFF_FFFF;
            endcase
         default: w = $urandom_range(0, 32'hFFFFFF);
      endcase
      if ($urandom_range(1) && w != 32'h8000_0000) w = -w;
      return w;
   endfunction

   function automatic particle_type random_particle();
      particle_type p;
      p.op = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: p.mass = $urandom;
         1: p.mass = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
         default: p.mass = $urandom_range(32'h100, 32'h7FFFFF);
      endcase
      if (p.mass == 0) p.mass = 1;
      case ($urandom_range(3))
         0: p.beta = 0;
         1: p.beta = 16'hFFFF;
         default: p.beta = 16'($urandom);
      endcase
      for (int d = 0; d < 3; d++) begin
         p.force_v[d] = pick_word();
         p.vel[d]     = pick_word();
         p.pos[d]     = pick_word();
      end
      return p;
   endfunction

   function automatic particle_type uniform_particle(bit op, logic [31:0] mass,
                                                     logic [15:0] beta,
                                                     logic [31:0] f, logic [31:0] v,
                                                     logic [31:0] x);
      particle_type p;
      p.op = op;
      p.mass = mass;
      p.beta = beta;
      for (int d = 0; d < 3; d++) begin
         p.force_v[d] = f;
         p.vel[d]     = v;
         p.pos[d]     = x;
      end
      return p;
   endfunction

   initial begin
      particle_type p;
      logic [31:0]  kicks[6];
      logic [31:0]  drifts[6];
      kicks  = '{32'h0000_8000, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 0, 0};
      drifts = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0000_0100, 0, 0};
      kicks[4]  = $urandom;
      drifts[4] = $urandom;
      kicks[5]  = $urandom_range(0, 32'h3FFFF);
      drifts[5] = $urandom_range(0, 32'h3FFFF);
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      write_reg(REG_HALF_KICK, 32'h0001_0000);
      write_reg(REG_DRIFT, 32'h0001_0000);
      send_particle(uniform_particle(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0));
      send_particle(uniform_particle(1, 32'h0001_0000, 0, 32'h0001_0000, 32'h10, 32'h20));
      send_particle(uniform_particle(0, 32'd1, 0, 32'h7FFF_FFFF, 0, 0));
      send_particle(uniform_particle(1, 32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0000, 0, 0));
      send_particle(uniform_particle(0, 32'h0001_0000, 16'hFFFF, 32'h1, 0, 0));
      send_particle(uniform_particle(0, 32'h0001_0000, 16'h8000, 32'hFFFF_0000,
                                     32'h8000_0000, 32'h8000_0000));
      send_particle(uniform_particle(0, 32'h0001_0000, 0, 32'h0001_0000,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_particle(uniform_particle(1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_particle(uniform_particle(0, 32'd1, 16'h1234, 0, 32'h8000_0000, 32'h7FFF_FFFF));
      send_particle(uniform_particle(0, 32'h0000_0100, 0, 32'h0000_0100, 32'hFFFF_F000, 0));
      req_tvalid <= 0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_HALF_KICK, kicks[ph]);
         write_reg(REG_DRIFT, drifts[ph]);
         send_idle_pct = (ph < 2) ? 31 : (ph < 4) ? 56 : 0;
         recv_idle_pct = (ph < 2) ? 56 : (ph < 4) ? 31 : 0;
         for (int i = 0; i < 258; i++) begin
            if (ph == 4 && i == 40) hold_left = 300;
            p = random_particle();
            send_particle(p);
         end
         req_tvalid <= 0;
         drain();
      end

      if (sb.errors == 0)
         $display("tb_corrected_velocity_verlet_step passed");
      else
         $display("tb_corrected_velocity_verlet_step failed");
      $finish;
   end
endmodule
